@@ hw/rtl/tvs_pkg.sv @@
// Shared types and constants for the trilinear volume sampler.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none

package tvs_pkg;

  localparam int unsigned VALUE_W = 32;  // Q16.16 voxel and position width
  localparam int unsigned FRAC_W  = 16;  // fraction bits of a grid coordinate
  localparam int unsigned IDX_W   = 8;   // grid index bits (sizes up to 256)
  localparam int unsigned COORD_W = IDX_W + FRAC_W;
  localparam int unsigned CFG_W   = 3;   // configuration index width

  // Item commands.
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_W-1:0] REG_ORIGIN_X = 3'd0;
  localparam logic [CFG_W-1:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_W-1:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [CFG_W-1:0] REG_SCALE_X  = 3'd3;
  localparam logic [CFG_W-1:0] REG_SCALE_Y  = 3'd4;
  localparam logic [CFG_W-1:0] REG_SCALE_Z  = 3'd5;

  localparam logic [VALUE_W-1:0] SCALE_ONE = 32'h0001_0000;

endpackage

`default_nettype wire

@@ hw/rtl/tvs_coord.sv @@
// Two-stage unit that maps one world coordinate to a clamped grid coordinate.
// Depends on tvs_pkg for widths.
`default_nettype none

module tvs_coord (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                en_i,
  input  wire logic signed [tvs_pkg::VALUE_W-1:0]  pos_i,
  input  wire logic signed [tvs_pkg::VALUE_W-1:0]  origin_i,
  input  wire logic        [tvs_pkg::VALUE_W-1:0]  scale_i,
  input  wire logic        [tvs_pkg::IDX_W-1:0]    top_i,
  output logic             [tvs_pkg::COORD_W-1:0]  coord_o
);

  logic signed [32:0] diff;
  logic        [32:0] neg_diff;
  logic        [31:0] mag;
  logic        [63:0] prod_d, prod_q;
  logic               neg_q;
  logic [tvs_pkg::IDX_W-1:0] top_q;
  logic        [64:0] rnd;
  logic        [48:0] quo;
  logic               big;
  logic signed [26:0] half, full, qn, sum;

  assign diff     = $signed({pos_i[31], pos_i}) - $signed({origin_i[31], origin_i});
  assign neg_diff = -diff;
  assign mag      = diff[32] ? neg_diff[31:0] : diff[31:0];
  assign prod_d   = 64'(mag) * 64'(scale_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      neg_q <= 1'b0;
    end else if (en_i) begin
      neg_q <= diff[32];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      top_q  <= top_i;
    end
  end

  // A negative offset rounds its magnitude up, which floors the signed value.
  assign rnd  = {1'b0, prod_q} + (neg_q ? 65'd65535 : 65'd0);
  assign quo  = rnd[64:16];
  // Anything at or above 2^25 lies beyond every face of a 256-wide grid.
  assign big  = |quo[48:25];
  assign half = $signed({4'b0, top_q, 15'b0});
  assign full = $signed({3'b0, top_q, 16'b0});
  assign qn   = $signed({2'b0, quo[24:0]});
  assign sum  = neg_q ? (half - qn) : (half + qn);

  always_comb begin
    if (big) begin
      coord_o = neg_q ? '0 : full[tvs_pkg::COORD_W-1:0];
    end else if (sum < 0) begin
      coord_o = '0;
    end else if (sum > full) begin
      coord_o = full[tvs_pkg::COORD_W-1:0];
    end else begin
      coord_o = sum[tvs_pkg::COORD_W-1:0];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/tvs_lerp.sv @@
// Shared two-stage linear blend: a + floor((b - a) * f / 65536).
// Depends on tvs_pkg for widths.
`default_nettype none

module tvs_lerp (
  input  wire logic                                clk_i,
  input  wire logic                                en_i,
  input  wire logic signed [tvs_pkg::VALUE_W-1:0]  a_i,
  input  wire logic signed [tvs_pkg::VALUE_W-1:0]  b_i,
  input  wire logic        [tvs_pkg::FRAC_W-1:0]   f_i,
  output logic signed      [tvs_pkg::VALUE_W-1:0]  res_o
);

  logic signed [32:0] diff;
  logic signed [16:0] frac;
  logic signed [49:0] prod_d, prod_q;
  logic signed [31:0] a_q;
  logic signed [33:0] sum;

  assign diff   = $signed({b_i[31], b_i}) - $signed({a_i[31], a_i});
  assign frac   = $signed({1'b0, f_i});
  assign prod_d = 50'(diff) * 50'(frac);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      a_q    <= a_i;
    end
  end

  // The blend is a convex combination, so the sum always fits in 32 bits.
  assign sum   = $signed({{2{a_q[31]}}, a_q}) + $signed(prod_q[49:16]);
  assign res_o = sum[31:0];

endmodule

`default_nettype wire

@@ hw/rtl/trilinear_volume_sampler.sv @@
// Trilinear volume sampler: voxel store, coordinate unit and blend sequencer.
// A write item does not hold up the input. A query item holds the input until
// its result is loaded into the output register, which can wait on out_ready_i;
// each query makes eight corner reads through the single memory read port plus
// seven passes through the shared blend unit. Reset clears control state,
// origin to zero and scale to 1.0; voxel contents stay undefined until written.
`default_nettype none

module trilinear_volume_sampler #(
  parameter int unsigned GRID_X = 32,
  parameter int unsigned GRID_Y = 32,
  parameter int unsigned GRID_Z = 32
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [tvs_pkg::CFG_W-1:0]          cfg_index_i,
  input  wire logic [tvs_pkg::VALUE_W-1:0]        cfg_data_i,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic                               command_i,
  input  wire logic [4:0]                         voxel_x_i,
  input  wire logic [4:0]                         voxel_y_i,
  input  wire logic [4:0]                         voxel_z_i,
  input  wire logic signed [tvs_pkg::VALUE_W-1:0] voxel_value_i,
  input  wire logic signed [tvs_pkg::VALUE_W-1:0] pos_x_i,
  input  wire logic signed [tvs_pkg::VALUE_W-1:0] pos_y_i,
  input  wire logic signed [tvs_pkg::VALUE_W-1:0] pos_z_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic signed [tvs_pkg::VALUE_W-1:0]      sample_value_o
);

  localparam int unsigned DEPTH = GRID_X * GRID_Y * GRID_Z;
  localparam int unsigned AW    = $clog2(DEPTH);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_COORD = 5'b00010,
    S_READ  = 5'b00100,
    S_BLEND = 5'b01000,
    S_OUT   = 5'b10000
  } state_e;

  typedef logic signed [tvs_pkg::VALUE_W-1:0] value_t;
  typedef logic [tvs_pkg::COORD_W-1:0]        coord_t;
  typedef logic [tvs_pkg::IDX_W-1:0]          idx_t;

  state_e state_q, state_d;
  logic [3:0] cnt_q, cnt_d;

  value_t origin_q [3];
  logic [tvs_pkg::VALUE_W-1:0] scale_q [3];
  value_t pos_q [3];
  coord_t c_q [3];
  value_t xv_q [4];
  value_t first_q, yv0_q, yv1_q, res_q;
  value_t sample_q;
  logic   out_valid_q;

  logic [tvs_pkg::VALUE_W-1:0] mem_q [DEPTH];
  value_t  rdata_q;
  logic [AW-1:0] waddr, raddr;
  logic    mem_we;

  logic in_acc, in_range, out_load;
  logic [1:0] feed_ax, cap_ax, xv_idx;
  idx_t top_sel;
  coord_t coord;
  logic coord_en;

  idx_t lo_x, lo_y, lo_z, hi_x, hi_y, hi_z, rx, ry, rz;
  logic [tvs_pkg::FRAC_W-1:0] fx, fy, fz;

  logic   lerp_en;
  value_t lerp_a, lerp_b, lerp_res;
  logic [tvs_pkg::FRAC_W-1:0] lerp_f;

  assign cfg_ready_o    = 1'b1;
  assign in_ready_o     = (state_q == S_IDLE);
  assign in_acc         = in_valid_i && in_ready_o;
  assign out_valid_o    = out_valid_q;
  assign sample_value_o = sample_q;

  // ---------------- configuration ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_q[0] <= '0;
      origin_q[1] <= '0;
      origin_q[2] <= '0;
      scale_q[0]  <= tvs_pkg::SCALE_ONE;
      scale_q[1]  <= tvs_pkg::SCALE_ONE;
      scale_q[2]  <= tvs_pkg::SCALE_ONE;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        tvs_pkg::REG_ORIGIN_X: origin_q[0] <= cfg_data_i;
        tvs_pkg::REG_ORIGIN_Y: origin_q[1] <= cfg_data_i;
        tvs_pkg::REG_ORIGIN_Z: origin_q[2] <= cfg_data_i;
        tvs_pkg::REG_SCALE_X:  scale_q[0]  <= cfg_data_i;
        tvs_pkg::REG_SCALE_Y:  scale_q[1]  <= cfg_data_i;
        tvs_pkg::REG_SCALE_Z:  scale_q[2]  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------- voxel store ----------------
  assign in_range = ({4'b0, voxel_x_i} < 9'(GRID_X)) && ({4'b0, voxel_y_i} < 9'(GRID_Y))
                 && ({4'b0, voxel_z_i} < 9'(GRID_Z));
  assign mem_we   = in_acc && (command_i == tvs_pkg::CMD_WRITE) && in_range;
  assign waddr    = AW'((32'(voxel_x_i) * 32'(GRID_Y) + 32'(voxel_y_i)) * 32'(GRID_Z)
                        + 32'(voxel_z_i));

  // Corner order: bit 0 picks the upper X, bit 1 the upper Z, bit 2 the upper Y,
  // so each pair of reads is one X blend.
  assign rx    = cnt_q[0] ? hi_x : lo_x;
  assign rz    = cnt_q[1] ? hi_z : lo_z;
  assign ry    = cnt_q[2] ? hi_y : lo_y;
  assign raddr = AW'((32'(rx) * 32'(GRID_Y) + 32'(ry)) * 32'(GRID_Z) + 32'(rz));

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[waddr] <= voxel_value_i;
    end
    rdata_q <= mem_q[raddr];
  end

  // ---------------- coordinates ----------------
  assign lo_x = c_q[0][tvs_pkg::COORD_W-1:tvs_pkg::FRAC_W];
  assign lo_y = c_q[1][tvs_pkg::COORD_W-1:tvs_pkg::FRAC_W];
  assign lo_z = c_q[2][tvs_pkg::COORD_W-1:tvs_pkg::FRAC_W];
  assign fx   = c_q[0][tvs_pkg::FRAC_W-1:0];
  assign fy   = c_q[1][tvs_pkg::FRAC_W-1:0];
  assign fz   = c_q[2][tvs_pkg::FRAC_W-1:0];
  assign hi_x = lo_x + idx_t'(fx != '0);
  assign hi_y = lo_y + idx_t'(fy != '0);
  assign hi_z = lo_z + idx_t'(fz != '0);

  assign feed_ax  = (cnt_q[1:0] == 2'd3) ? 2'd2 : cnt_q[1:0];
  assign cap_ax   = 2'(cnt_q - 4'd1);
  assign coord_en = (state_q == S_COORD) && (cnt_q < 4'd3);

  always_comb begin
    case (feed_ax)
      2'd0:    top_sel = idx_t'(GRID_X - 1);
      2'd1:    top_sel = idx_t'(GRID_Y - 1);
      default: top_sel = idx_t'(GRID_Z - 1);
    endcase
  end

  tvs_coord u_coord (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (coord_en),
    .pos_i    (pos_q[feed_ax]),
    .origin_i (origin_q[feed_ax]),
    .scale_i  (scale_q[feed_ax]),
    .top_i    (top_sel),
    .coord_o  (coord)
  );

  // ---------------- blend ----------------
  assign xv_idx = 2'(cnt_q[3:1] - 3'd1);

  always_comb begin
    lerp_en = 1'b0;
    lerp_a  = first_q;
    lerp_b  = rdata_q;
    lerp_f  = fx;
    case (state_q)
      S_READ: begin
        lerp_en = (cnt_q >= 4'd2) && (cnt_q <= 4'd8) && !cnt_q[0];
      end
      S_BLEND: begin
        case (cnt_q)
          4'd0: begin
            lerp_en = 1'b1;
            lerp_a  = xv_q[0];
            lerp_b  = xv_q[2];
            lerp_f  = fy;
          end
          4'd1: begin
            lerp_en = 1'b1;
            lerp_a  = xv_q[1];
            lerp_b  = xv_q[3];
            lerp_f  = fy;
          end
          4'd3: begin
            lerp_en = 1'b1;
            lerp_a  = yv0_q;
            lerp_b  = yv1_q;
            lerp_f  = fz;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  tvs_lerp u_lerp (
    .clk_i (clk_i),
    .en_i  (lerp_en),
    .a_i   (lerp_a),
    .b_i   (lerp_b),
    .f_i   (lerp_f),
    .res_o (lerp_res)
  );

  always_ff @(posedge clk_i) begin
    if (in_acc && (command_i == tvs_pkg::CMD_QUERY)) begin
      pos_q[0] <= pos_x_i;
      pos_q[1] <= pos_y_i;
      pos_q[2] <= pos_z_i;
    end
    if ((state_q == S_COORD) && (cnt_q != 4'd0)) begin
      c_q[cap_ax] <= coord;
    end
    if ((state_q == S_READ) && cnt_q[0] && (cnt_q <= 4'd7)) begin
      first_q <= rdata_q;
    end
    if ((state_q == S_READ) && cnt_q[0] && (cnt_q >= 4'd3)) begin
      xv_q[xv_idx] <= lerp_res;
    end
    if ((state_q == S_BLEND) && (cnt_q == 4'd1)) begin
      yv0_q <= lerp_res;
    end
    if ((state_q == S_BLEND) && (cnt_q == 4'd2)) begin
      yv1_q <= lerp_res;
    end
    if ((state_q == S_BLEND) && (cnt_q == 4'd4)) begin
      res_q <= lerp_res;
    end
    if (out_load) begin
      sample_q <= res_q;
    end
  end

  // ---------------- sequencer ----------------
  assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q + 4'd1;
    case (state_q)
      S_IDLE: begin
        cnt_d = '0;
        if (in_acc && (command_i == tvs_pkg::CMD_QUERY)) begin
          state_d = S_COORD;
        end
      end
      S_COORD: begin
        if (cnt_q == 4'd3) begin
          state_d = S_READ;
          cnt_d   = '0;
        end
      end
      S_READ: begin
        if (cnt_q == 4'd9) begin
          state_d = S_BLEND;
          cnt_d   = '0;
        end
      end
      S_BLEND: begin
        if (cnt_q == 4'd4) begin
          state_d = S_OUT;
          cnt_d   = '0;
        end
      end
      S_OUT: begin
        cnt_d = '0;
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
        cnt_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------- assertions ----------------
  a_write_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (command_i == tvs_pkg::CMD_WRITE) && !out_valid_q) |=> !out_valid_q)
    else $error("write item produced a result");

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (command_i == tvs_pkg::CMD_QUERY)) |=> !in_ready_o)
    else $error("block took a new item while a query was in flight");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_OUT))
    else $error("result appeared outside the output step");

  a_read_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> (cnt_q <= 4'd9))
    else $error("corner read counter ran past its last step");

endmodule

`default_nettype wire
